@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising edge, off during reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property failed");

// Condition that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant failed");

`endif

@@ hw/rtl/elu3d_pkg.sv @@
package elu3d_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int SPACING_WIDTH       = 25;
    localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 25'd262144;

    localparam int DIV3_SHIFT = 31;
    localparam int DIV3_WIDTH = 30;
    localparam logic [DIV3_WIDTH-1:0] DIV3_MULT = 30'd715827883;

    typedef enum logic [1:0] {
        CASE_ONE   = 2'd0,
        CASE_TWO   = 2'd1,
        CASE_THREE = 2'd2
    } case_code_t;

endpackage

@@ hw/rtl/elu3d_sqrt_pipe.sv @@
module elu3d_sqrt_pipe #(
    parameter int RAD_WIDTH = 52
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [RAD_WIDTH-1:0]   radicand,
    output logic [RAD_WIDTH/2-1:0] root
);

    localparam int QW = RAD_WIDTH / 2;

    logic [RAD_WIDTH-1:0] rad_reg  [QW];
    logic [QW+1:0]        rem_reg  [QW];
    logic [QW-1:0]        root_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RAD_WIDTH-1:0] rad_in;
        logic [QW+1:0]        rem_in;
        logic [QW-1:0]        root_in;
        logic [QW+3:0]        cur;
        logic [QW+3:0]        trial;
        logic                 ge;
        logic [QW+3:0]        diff;
        logic [RAD_WIDTH-1:0] rad_next;
        logic [QW+1:0]        rem_next;
        logic [QW-1:0]        root_next;

        if (k == 0) begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            cur       = {rem_in, rad_in[RAD_WIDTH-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            ge        = (cur >= trial);
            diff      = cur - trial;
            rem_next  = ge ? diff[QW+1:0] : cur[QW+1:0];
            root_next = {root_in[QW-2:0], ge};
            rad_next  = {rad_in[RAD_WIDTH-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[QW-1];

endmodule

@@ hw/rtl/eikonal_local_update_3d_core.sv @@
// Pipeline: 5 front stages, 26 root stages, 3 combine stages and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, asynchronous): pipeline emptied, grid spacing back to 1/64.
module eikonal_local_update_3d_core #(
    parameter int VALUE_WIDTH = elu3d_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                                   cfg_we,
    input  logic [elu3d_pkg::SPACING_WIDTH-1:0]    cfg_data,   // grid_spacing
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // center_value, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus
    input  logic [((7*VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // distance, case_used, discriminant_clamped
    output logic [((VALUE_WIDTH+3+7)/8)*8-1:0]     m_tdata
);

    localparam int W      = VALUE_WIDTH;
    localparam int SW     = elu3d_pkg::SPACING_WIDTH;
    localparam int XW     = (W > SW + 2) ? W : SW + 2;
    localparam int RW     = 2 * SW + 2;
    localparam int QW     = RW / 2;
    localparam int SQW    = 2 * SW + 4;
    localparam int NW     = SW + 3;
    localparam int PW     = NW + elu3d_pkg::DIV3_WIDTH;
    localparam int OUT_TW = ((W + 3 + 7) / 8) * 8;

    typedef struct packed {
        logic [XW-1:0] a;
        logic [XW-1:0] c;
        logic [SW-1:0] ba;
        logic [SW:0]   ca;
        logic          one;
        logic          clamped;
        logic          cneg;
        logic          czero;
    } side_t;

    logic en;
    logic [SW-1:0] spacing_reg;
    logic [XW-1:0] h_x;

    // stage 1
    logic          v1_reg;
    logic [XW-1:0] a1_reg, b1_reg, c1_reg;
    logic          cneg1_reg, czero1_reg;
    logic [W-1:0]  mag_next [6];
    logic [XW-1:0] a1_next, b1_next, c1_next;

    // stage 2
    logic          v2_reg;
    logic [XW-1:0] a2_reg, b2_reg, c2_reg;
    logic          cneg2_reg, czero2_reg;
    logic [XW-1:0] lo, hi, mid, a2_next, b2_next, c2_next;

    // stage 3
    logic          v3_reg;
    logic [XW-1:0] a3_reg, c3_reg;
    logic [SW-1:0] ba3_reg;
    logic [SW:0]   ca3_reg, cb3_reg;
    logic          one3_reg, cneg3_reg, czero3_reg;
    logic [XW-1:0] ba_full, ca_full, cb_full;

    // stage 4
    logic            v4_reg;
    logic [2*SW-1:0] hh4_reg, ba2_4_reg;
    logic [2*SW+1:0] ca2_4_reg, cb2_4_reg;
    side_t           side4_reg;

    // stage 5
    logic          v5_reg;
    logic [RW-1:0] rad2_5_reg, disc5_reg;
    side_t         side5_reg;
    logic [SQW-1:0] sq_next, three_next;
    logic [RW-1:0]  rad2_next;
    side_t          side5_next;

    // root stages
    logic [QW-1:0] s2_root, s3_root;
    logic          vq_reg   [QW];
    side_t         sideq_reg[QW];
    side_t         sq_side;

    // stage A
    logic          va_reg;
    logic [XW:0]   d2a_reg;
    logic [NW-1:0] n3a_reg;
    side_t         sidea_reg;
    logic [XW:0]   sum_ba_s2;

    // stage B
    logic          vb_reg;
    logic [PW-1:0] prodb_reg;
    logic [XW:0]   d2b_reg;
    logic          case2b_reg;
    side_t         sideb_reg;

    // stage C
    logic          vc_reg;
    logic [XW:0]   dc_reg;
    elu3d_pkg::case_code_t casec_reg;
    logic          clampc_reg, cnegc_reg, czeroc_reg;
    logic [XW:0]   dc_next;
    logic [XW:0]   q_x;
    elu3d_pkg::case_code_t casec_next;

    // output
    logic          vo_reg;
    logic [W-1:0]  dist_reg;
    elu3d_pkg::case_code_t caseo_reg;
    logic          clampo_reg;
    logic [W-1:0]  dist_next;
    logic [XW:0]   pos_max, neg_max, dneg;

    function automatic logic [W-1:0] magn(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign en       = !vo_reg || m_tready;
    assign s_tready = en;
    assign h_x      = XW'(spacing_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= elu3d_pkg::SPACING_RESET;
        else if (cfg_we)
            spacing_reg <= cfg_data;
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            mag_next[k] = magn(s_tdata[(k+1)*W +: W]);
        a1_next = XW'((mag_next[0] < mag_next[1]) ? mag_next[0] : mag_next[1]);
        b1_next = XW'((mag_next[2] < mag_next[3]) ? mag_next[2] : mag_next[3]);
        c1_next = XW'((mag_next[4] < mag_next[5]) ? mag_next[4] : mag_next[5]);
    end

    always_comb
    begin
        lo      = (b1_reg < a1_reg) ? b1_reg : a1_reg;
        hi      = (b1_reg < a1_reg) ? a1_reg : b1_reg;
        c2_next = (c1_reg < hi) ? hi : c1_reg;
        mid     = (c1_reg < hi) ? c1_reg : hi;
        a2_next = (mid < lo) ? mid : lo;
        b2_next = (mid < lo) ? lo : mid;
    end

    always_comb
    begin
        ba_full = b2_reg - a2_reg;
        ca_full = c2_reg - a2_reg;
        cb_full = c2_reg - b2_reg;
    end

    always_comb
    begin
        rad2_next  = {hh4_reg, 1'b0} - RW'(ba2_4_reg);
        sq_next    = SQW'(ba2_4_reg) + SQW'(ca2_4_reg) + SQW'(cb2_4_reg);
        three_next = SQW'({hh4_reg, 1'b0}) + SQW'(hh4_reg);
        side5_next         = side4_reg;
        side5_next.clamped = (sq_next > three_next);
    end

    assign sq_side   = sideq_reg[QW-1];
    assign sum_ba_s2 = (XW+1)'(sq_side.ba) + (XW+1)'(s2_root);
    assign q_x       = (XW+1)'(prodb_reg[PW-1:elu3d_pkg::DIV3_SHIFT]);

    always_comb
    begin
        if (sideb_reg.one)
        begin
            dc_next    = (XW+1)'(sideb_reg.a) + (XW+1)'(h_x);
            casec_next = elu3d_pkg::CASE_ONE;
        end
        else if (case2b_reg)
        begin
            dc_next    = (XW+1)'(sideb_reg.a) + q_x;
            casec_next = elu3d_pkg::CASE_THREE;
        end
        else
        begin
            dc_next    = d2b_reg;
            casec_next = elu3d_pkg::CASE_TWO;
        end
    end

    always_comb
    begin
        pos_max = (XW+1)'({1'b0, {(W-1){1'b1}}});
        neg_max = (XW+1)'({1'b1, {(W-1){1'b0}}});
        dneg    = ~dc_reg + (XW+1)'(1);
        if (czeroc_reg)
            dist_next = '0;
        else if (cnegc_reg)
            dist_next = (dc_reg > neg_max) ? {1'b1, {(W-1){1'b0}}} : dneg[W-1:0];
        else
            dist_next = (dc_reg > pos_max) ? {1'b0, {(W-1){1'b1}}} : dc_reg[W-1:0];
    end

    elu3d_sqrt_pipe #(.RAD_WIDTH(RW)) u_sqrt_two (
        .clk      (clk),
        .en       (en),
        .radicand (rad2_5_reg),
        .root     (s2_root)
    );

    elu3d_sqrt_pipe #(.RAD_WIDTH(RW)) u_sqrt_three (
        .clk      (clk),
        .en       (en),
        .radicand (disc5_reg),
        .root     (s3_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
                vq_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vq_reg[0] <= v5_reg;
            for (int k = 1; k < QW; k++)
                vq_reg[k] <= vq_reg[k-1];
            va_reg <= vq_reg[QW-1];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vo_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg     <= a1_next;
            b1_reg     <= b1_next;
            c1_reg     <= c1_next;
            cneg1_reg  <= s_tdata[W-1];
            czero1_reg <= (s_tdata[W-1:0] == '0);

            a2_reg     <= a2_next;
            b2_reg     <= b2_next;
            c2_reg     <= c2_next;
            cneg2_reg  <= cneg1_reg;
            czero2_reg <= czero1_reg;

            a3_reg     <= a2_reg;
            c3_reg     <= c2_reg;
            ba3_reg    <= ba_full[SW-1:0];
            ca3_reg    <= ca_full[SW:0];
            cb3_reg    <= cb_full[SW:0];
            one3_reg   <= (ba_full >= h_x);
            cneg3_reg  <= cneg2_reg;
            czero3_reg <= czero2_reg;

            hh4_reg    <= spacing_reg * spacing_reg;
            ba2_4_reg  <= ba3_reg * ba3_reg;
            ca2_4_reg  <= ca3_reg * ca3_reg;
            cb2_4_reg  <= cb3_reg * cb3_reg;
            side4_reg  <= '{a: a3_reg, c: c3_reg, ba: ba3_reg, ca: ca3_reg,
                            one: one3_reg, clamped: 1'b0, cneg: cneg3_reg,
                            czero: czero3_reg};

            rad2_5_reg <= rad2_next;
            disc5_reg  <= (sq_next > three_next) ? '0 : RW'(three_next - sq_next);
            side5_reg  <= side5_next;

            sideq_reg[0] <= side5_reg;
            for (int k = 1; k < QW; k++)
                sideq_reg[k] <= sideq_reg[k-1];

            d2a_reg   <= (XW+1)'(sq_side.a) + (sum_ba_s2 >> 1);
            n3a_reg   <= NW'(sq_side.ba) + NW'(sq_side.ca) + NW'(s3_root);
            sidea_reg <= sq_side;

            prodb_reg  <= PW'(n3a_reg) * PW'(elu3d_pkg::DIV3_MULT);
            d2b_reg    <= d2a_reg;
            case2b_reg <= !sidea_reg.one && (d2a_reg > (XW+1)'(sidea_reg.c));
            sideb_reg  <= sidea_reg;

            dc_reg     <= dc_next;
            casec_reg  <= casec_next;
            clampc_reg <= !sideb_reg.one && case2b_reg && sideb_reg.clamped;
            cnegc_reg  <= sideb_reg.cneg;
            czeroc_reg <= sideb_reg.czero;

            dist_reg   <= dist_next;
            caseo_reg  <= casec_reg;
            clampo_reg <= clampc_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_TW'({clampo_reg, caseo_reg, dist_reg});

endmodule

@@ hw/rtl/elu3d_checker.sv @@
`include "assert_macros.svh"

module elu3d_checker #(
    parameter int VALUE_WIDTH = elu3d_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((VALUE_WIDTH+3+7)/8)*8-1:0]     m_tdata
);

    localparam int W = VALUE_WIDTH;

    `ASSERT_PROP(a_hold_result, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid)
    `ASSERT_ALWAYS(a_ready_follows_output, clk, rst_n, s_tready == (!m_tvalid || m_tready))
    `ASSERT_PROP(a_case_code, clk, rst_n, m_tvalid |-> (m_tdata[W+1:W] != 2'd3))
    `ASSERT_PROP(a_clamp_three, clk, rst_n, (m_tvalid && m_tdata[W+2]) |-> (m_tdata[W+1:W] == elu3d_pkg::CASE_THREE))

endmodule

bind eikonal_local_update_3d_core elu3d_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_elu3d_checker (.*);

@@ bench/eikonal_local_update_3d_core_test.sv @@
`timescale 1ns / 1ps

module eikonal_local_update_3d_core_test;

    localparam int VW = 32;
    localparam int IN_W = ((7*VW+7)/8)*8;
    localparam int OUT_W = ((VW+3+7)/8)*8;
    localparam int STALL_LIMIT = 20000;
    localparam int LATENCY = 35;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                  clamped;
        elu3d_pkg::case_code_t kind;
        logic [31:0]           distance;
    } update_t;

    typedef struct {
        logic [31:0] vals [7];
        logic        known;
        update_t     want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [elu3d_pkg::SPACING_WIDTH-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic [elu3d_pkg::SPACING_WIDTH-1:0] spacing = elu3d_pkg::SPACING_RESET;
    update_t pending_updates [$];
    int errors = 0;
    int idle_run = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    eikonal_local_update_3d_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] mag(input logic [31:0] v);
        return v[31] ? 64'(-v) & 64'hFFFF_FFFF : 64'(v);
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic update_t make_update(input logic [31:0] d,
                                            input elu3d_pkg::case_code_t k,
                                            input logic cl);
        update_t u;
        u.distance = d;
        u.kind = k;
        u.clamped = cl;
        return u;
    endfunction

    function automatic update_t solve_update(input logic [31:0] v [7],
                                             input logic [elu3d_pkg::SPACING_WIDTH-1:0] hs);
        update_t u;
        logic [63:0] a, b, c, t, h, hh, d, ba, ca, cb, sq, disc;
        a = mag(v[1]) < mag(v[2]) ? mag(v[1]) : mag(v[2]);
        b = mag(v[3]) < mag(v[4]) ? mag(v[3]) : mag(v[4]);
        c = mag(v[5]) < mag(v[6]) ? mag(v[5]) : mag(v[6]);
        if (b < a) begin t = a; a = b; b = t; end
        if (c < b)
        begin
            t = b; b = c; c = t;
            if (b < a) begin t = a; a = b; b = t; end
        end
        h = 64'(hs);
        hh = h * h;
        u.kind = elu3d_pkg::CASE_ONE;
        u.clamped = 1'b0;
        if (b - a >= h)
            d = a + h;
        else
        begin
            ba = b - a;
            d = a + ((ba + isqrt(2 * hh - ba * ba)) >> 1);
            u.kind = elu3d_pkg::CASE_TWO;
            if (d > c)
            begin
                ca = c - a;
                cb = c - b;
                sq = ba * ba + ca * ca + cb * cb;
                if (sq > 3 * hh)
                begin
                    disc = 0;
                    u.clamped = 1'b1;
                end
                else
                    disc = 3 * hh - sq;
                d = a + (ba + ca + isqrt(disc)) / 3;
                u.kind = elu3d_pkg::CASE_THREE;
            end
        end
        if (v[0] == 0)
            u.distance = 0;
        else if (v[0][31])
            u.distance = d > 64'h8000_0000 ? MOST_NEG : 32'(-d);
        else
            u.distance = d > 64'h7FFF_FFFF ? MOST_POS : d[31:0];
        return u;
    endfunction

    // check results at the rising edge
    always @(posedge clk)
    begin
        update_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = update_t'(m_tdata[VW+2:0]);
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (got.distance !== want.distance)
                begin
                    $display("%0t: distance expected %h actual %h", $time, want.distance,
                             got.distance);
                    errors++;
                end
                if (got.kind !== want.kind)
                begin
                    $display("%0t: case expected %0d actual %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.clamped !== want.clamped)
                begin
                    $display("%0t: clamp expected %b actual %b", $time, want.clamped,
                             got.clamped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic [31:0] v [7], input logic known, input update_t given);
        update_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        want = solve_update(v, spacing);
        if (known && want !== given)
        begin
            $display("%0t: table row expected %h predicted %h", $time, given, want);
            errors++;
        end
        pending_updates = {pending_updates, want};
        s_tvalid <= 1'b1;
        s_tdata <= {v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_spacing(input logic [elu3d_pkg::SPACING_WIDTH-1:0] hs);
        cfg_we <= 1'b1;
        cfg_data <= hs;
        @(negedge clk);
        cfg_we <= 1'b0;
        spacing = hs;
    endtask

    function automatic logic [31:0] rand_value(input logic [elu3d_pkg::SPACING_WIDTH-1:0] hs);
        logic [31:0] m;
        case ($urandom_range(5))
            0: m = $urandom;
            1: m = $urandom_range(8) == 0 ? MOST_NEG : 32'($urandom_range(3));
            default: m = 32'($urandom_range(4 * hs + 4));
        endcase
        if ($urandom_range(1)) m = -m;
        return m;
    endfunction

    task automatic random_items(input int count);
        logic [31:0] v [7];
        logic [31:0] base;
        update_t none;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            base = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(200 * spacing));
            for (int k = 0; k < 7; k++)
            begin
                if (k > 0 && $urandom_range(2) != 0)
                    v[k] = base + 32'($urandom_range(2 * spacing + 2));
                else
                    v[k] = rand_value(spacing);
                if (k > 0 && $urandom_range(1)) v[k] = -v[k];
            end
            if ($urandom_range(20) == 0) v[0] = 0;
            send_item(v, 1'b0, none);
        end
    endtask

    row_t rows [$];

    task automatic add_row(input logic [31:0] c, x0, x1, y0, y1, z0, z1,
                           input logic known, input update_t want);
        row_t r;
        r.vals = '{c, x0, x1, y0, y1, z0, z1};
        r.known = known;
        r.want = want;
        rows = {rows, r};
    endtask

    localparam logic [31:0] H = 32'd262144;
    localparam logic [31:0] ONE = 32'h0100_0000;

    initial
    begin
        update_t none;
        none = '0;
        // one neighbour, zero centre, saturation, most negative
        add_row(ONE, 0, ONE, ONE, ONE, ONE, ONE, 1,
                make_update(H, elu3d_pkg::CASE_ONE, 1'b0));
        add_row(-ONE, 0, ONE, ONE, ONE, ONE, ONE, 1,
                make_update(-H, elu3d_pkg::CASE_ONE, 1'b0));
        add_row(0, 0, ONE, ONE, ONE, ONE, ONE, 1,
                make_update(32'd0, elu3d_pkg::CASE_ONE, 1'b0));
        add_row(MOST_POS, MOST_POS, MOST_NEG, MOST_POS, MOST_POS, MOST_POS, MOST_POS,
                1, make_update(MOST_POS, elu3d_pkg::CASE_THREE, 1'b0));
        add_row(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                1, make_update(MOST_NEG, elu3d_pkg::CASE_THREE, 1'b0));
        add_row(ONE, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(ONE, 0, ONE, H / 2, ONE, ONE, ONE, 0, none);
        add_row(-ONE, 0, ONE, H / 2, ONE, H / 2, ONE, 0, none);
        add_row(ONE, 0, 0, H, H, H, H, 0, none);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 2, -2, 3, -3, 0, none);
        add_row(1, MOST_POS, MOST_POS, MOST_POS, MOST_POS, 0, MOST_POS, 0, none);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, none);

        s_tvalid <= 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 85;
        foreach (rows[i])
            send_item(rows[i].vals, rows[i].known, rows[i].want);
        drain_pipeline();
        write_spacing(0);
        foreach (rows[i])
            send_item(rows[i].vals, 1'b0, none);
        drain_pipeline();
        write_spacing(elu3d_pkg::SPACING_RESET);
        random_items(330);

        drain_pipeline();
        write_spacing(25'h1FF_FFFF);
        send_idle_pct = 85;
        recv_idle_pct = 37;
        random_items(220);
        drain_pipeline();
        write_spacing(1);
        random_items(120);

        drain_pipeline();
        write_spacing(25'h100_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(200);
        drain_pipeline();
        write_spacing(25'($urandom_range(1, 25'h100_0000)));
        random_items(150);

        drain_pipeline();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
